[sv/complex_arith_unit_macros.svh]
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CAU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("complex_arith_unit assertion failed");
`define CAU_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("complex_arith_unit assertion failed");
`else
`define CAU_ASSERT(lbl, clk, rstn, prop)
`define CAU_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

[sv/cau_pkg.sv]
// package: types, constants and helpers of the complex arithmetic unit
`default_nettype none
package cau_pkg;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned QBITS         = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned FRONT_STAGES  = 3;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              ov;
    logic              dz;
  } res_t;

  typedef struct packed {
    res_t        res;
    logic        is_div;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [31:0] lo_re;
    logic [31:0] lo_im;
    logic [QBITS-1:0] q_re;
    logic [QBITS-1:0] q_im;
  } dpl_t;

  // saturate to signed 32 bits, msb of result is the overflow flag
  function automatic logic [DATA_W:0] sat32(logic signed [65:0] v);
    logic [DATA_W:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction
endpackage
`default_nettype wire

[sv/complex_arith_unit.sv]
// top level: pipelined complex add, subtract, multiply and divide in fixed point
//
// operands enter on the op channel (op_valid_i/op_ready_o) with a mode; one
// result leaves on the res channel (res_valid_o/res_ready_i) per transaction.
// modes: add, subtract, multiply (ac-bd, ad+bc) and divide (a*conj(b)/|b|^2),
// each part saturated to signed 32 bits with overflow_o raised on saturation.
// a divisor of zero gives a zero result with div_zero_o raised.
// the pipeline has three front stages (products, sums, divider setup),
// 32 restoring division steps, one per stage, and the output register.
// every mode flows through the same stages, so a transaction can enter
// each cycle and throughput is one result per cycle while the receiver accepts results.
// each stage holds its item while the stage after it is full and held, so a
// stalled receiver backs the pipeline up stage by stage; bubbles still fill behind.
// reset clears all valid bits; the pipeline is empty and ready after reset.
`default_nettype none
`include "complex_arith_unit_macros.svh"
module complex_arith_unit #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               op_valid_i,
  output logic                    op_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic signed [31:0] a_re_i,
  input  wire logic signed [31:0] a_im_i,
  input  wire logic signed [31:0] b_re_i,
  input  wire logic signed [31:0] b_im_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic signed [31:0]      res_re_o,
  output logic signed [31:0]      res_im_o,
  output logic                    overflow_o,
  output logic                    div_zero_o
);
  localparam int unsigned NST = cau_pkg::FRONT_STAGES + cau_pkg::QBITS + 1;

  logic [NST-1:0] v_q;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = res_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= op_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  cau_pkg::dpl_t pl [0:cau_pkg::QBITS];

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i  (clk_i),
    .en_i   (en[2:0]),
    .mode_i (mode_i),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .pl_o   (pl[0])
  );

  for (genvar i = 0; i < cau_pkg::QBITS; i++) begin : g_step
    cau_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en[cau_pkg::FRONT_STAGES + i]),
      .pl_i  (pl[i]),
      .pl_o  (pl[i+1])
    );
  end

  function automatic logic [32:0] fin_part(logic neg, logic ovf, logic [31:0] q);
    logic [32:0] r;
    if (!neg) begin
      if (ovf || q[31]) r = {1'b1, 32'h7fff_ffff};
      else              r = {1'b0, q};
    end else begin
      if (ovf || (q > 32'h8000_0000)) r = {1'b1, 32'h8000_0000};
      else                           r = {1'b0, 32'(-q)};
    end
    return r;
  endfunction

  cau_pkg::dpl_t lst;
  cau_pkg::res_t res_d, res_q;
  logic [32:0]   fr, fi;

  always_comb begin
    lst   = pl[cau_pkg::QBITS];
    fr    = fin_part(lst.neg_re, lst.ovf_re, lst.q_re);
    fi    = fin_part(lst.neg_im, lst.ovf_im, lst.q_im);
    res_d = lst.res;
    if (lst.is_div) begin
      res_d.re = fr[31:0];
      res_d.im = fi[31:0];
      res_d.ov = fr[32] | fi[32];
      res_d.dz = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      res_q <= res_d;
    end
  end

  assign op_ready_o  = en[0];
  assign res_valid_o = v_q[NST-1];
  assign res_re_o    = res_q.re;
  assign res_im_o    = res_q.im;
  assign overflow_o  = res_q.ov;
  assign div_zero_o  = res_q.dz;

  // divide by zero gives a clean zero result
  `CAU_ASSERT(a_dz_zero, clk_i, rst_ni, res_valid_o && div_zero_o |-> !overflow_o && res_re_o == 0 && res_im_o == 0)
  // overflow means some part sits at a rail
  `CAU_ASSERT(a_ov_rail, clk_i, rst_ni, res_valid_o && overflow_o |-> res_re_o == 32'sh7fff_ffff || res_re_o == 32'sh8000_0000 || res_im_o == 32'sh7fff_ffff || res_im_o == 32'sh8000_0000)
  // backpressure at the input only when the whole pipeline is full and stalled
  `CAU_ASSERT(a_full_stall, clk_i, rst_ni, !op_ready_o |-> res_valid_o && !res_ready_i && (&v_q))
  // no result while reset is asserted
  `CAU_ASSERT_NORST(a_rst_empty, clk_i, !rst_ni |-> !res_valid_o)
endmodule
`default_nettype wire

[sv/cau_front.sv]
// front stages: products, sums, add/sub/mul results and divider setup
`default_nettype none
module cau_front #(
  parameter int unsigned FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic [2:0]          en_i,
  input  wire logic [1:0]          mode_i,
  input  wire logic signed [31:0]  a_re_i,
  input  wire logic signed [31:0]  a_im_i,
  input  wire logic signed [31:0]  b_re_i,
  input  wire logic signed [31:0]  b_im_i,
  output cau_pkg::dpl_t            pl_o
);
  localparam int unsigned NW = 64 + FRAC_BITS;
  localparam int unsigned HW = NW - 32;

  // stage 1
  logic [1:0]         mode1_q;
  logic signed [63:0] ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
  cau_pkg::res_t      as1_q, as1_d;
  logic signed [32:0] sre, sim;
  logic [32:0]        sre_sat, sim_sat;

  always_comb begin
    if (mode_i == cau_pkg::MODE_SUB) begin
      sre = 33'(a_re_i) - 33'(b_re_i);
      sim = 33'(a_im_i) - 33'(b_im_i);
    end else begin
      sre = 33'(a_re_i) + 33'(b_re_i);
      sim = 33'(a_im_i) + 33'(b_im_i);
    end
    sre_sat  = cau_pkg::sat32(66'(sre));
    sim_sat  = cau_pkg::sat32(66'(sim));
    as1_d.re = sre_sat[31:0];
    as1_d.im = sim_sat[31:0];
    as1_d.ov = sre_sat[32] | sim_sat[32];
    as1_d.dz = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mode1_q <= mode_i;
      as1_q   <= as1_d;
      ac_q    <= a_re_i * b_re_i;
      bd_q    <= a_im_i * b_im_i;
      ad_q    <= a_re_i * b_im_i;
      bc_q    <= a_im_i * b_re_i;
      cc_q    <= b_re_i * b_re_i;
      dd_q    <= b_im_i * b_im_i;
    end
  end

  // stage 2
  logic               div2_q;
  cau_pkg::res_t      r2_q, r2_d;
  logic signed [64:0] nr_q, ni_q;
  logic [63:0]        den2_q;
  logic signed [65:0] mre, mim, mre_s, mim_s;
  logic [32:0]        mre_sat, mim_sat;

  always_comb begin
    mre     = 66'(ac_q) - 66'(bd_q);
    mim     = 66'(ad_q) + 66'(bc_q);
    mre_s   = mre >>> FRAC_BITS;
    mim_s   = mim >>> FRAC_BITS;
    mre_sat = cau_pkg::sat32(mre_s);
    mim_sat = cau_pkg::sat32(mim_s);
    if (mode1_q == cau_pkg::MODE_MUL) begin
      r2_d.re = mre_sat[31:0];
      r2_d.im = mim_sat[31:0];
      r2_d.ov = mre_sat[32] | mim_sat[32];
      r2_d.dz = 1'b0;
    end else begin
      r2_d = as1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      div2_q <= (mode1_q == cau_pkg::MODE_DIV);
      r2_q   <= r2_d;
      nr_q   <= 65'(ac_q) + 65'(bd_q);
      ni_q   <= 65'(bc_q) - 65'(ad_q);
      den2_q <= $unsigned(cc_q) + $unsigned(dd_q);
    end
  end

  // stage 3: divider setup
  cau_pkg::dpl_t  pl_d, pl_q;
  logic [64:0]    mag_re, mag_im;
  logic [NW-1:0]  n_re, n_im;
  logic [63:0]    hi_re, hi_im;
  logic           dz;

  always_comb begin
    mag_re = nr_q[64] ? 65'(-nr_q) : 65'(nr_q);
    mag_im = ni_q[64] ? 65'(-ni_q) : 65'(ni_q);
    n_re   = {mag_re[63:0], {FRAC_BITS{1'b0}}};
    n_im   = {mag_im[63:0], {FRAC_BITS{1'b0}}};
    hi_re  = {{(64-HW){1'b0}}, n_re[NW-1:32]};
    hi_im  = {{(64-HW){1'b0}}, n_im[NW-1:32]};
    dz     = div2_q && (den2_q == '0);
    pl_d.res    = r2_q;
    if (dz) begin
      pl_d.res = '0;
      pl_d.res.dz = 1'b1;
    end
    pl_d.is_div = div2_q && !dz;
    pl_d.neg_re = nr_q[64];
    pl_d.neg_im = ni_q[64];
    pl_d.ovf_re = hi_re >= den2_q;
    pl_d.ovf_im = hi_im >= den2_q;
    pl_d.den    = den2_q;
    pl_d.rem_re = hi_re;
    pl_d.rem_im = hi_im;
    pl_d.lo_re  = n_re[31:0];
    pl_d.lo_im  = n_im[31:0];
    pl_d.q_re   = '0;
    pl_d.q_im   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      pl_q <= pl_d;
    end
  end

  assign pl_o = pl_q;
endmodule
`default_nettype wire

[sv/cau_div_step.sv]
// one restoring division step for both result parts
`default_nettype none
module cau_div_step (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire cau_pkg::dpl_t pl_i,
  output cau_pkg::dpl_t      pl_o
);
  cau_pkg::dpl_t pl_d, pl_q;
  logic [64:0]   tr_re, tr_im;
  logic          ge_re, ge_im;

  always_comb begin
    tr_re = {pl_i.rem_re, pl_i.lo_re[31]};
    tr_im = {pl_i.rem_im, pl_i.lo_im[31]};
    ge_re = tr_re >= {1'b0, pl_i.den};
    ge_im = tr_im >= {1'b0, pl_i.den};
    pl_d  = pl_i;
    pl_d.rem_re = ge_re ? 64'(tr_re - {1'b0, pl_i.den}) : tr_re[63:0];
    pl_d.rem_im = ge_im ? 64'(tr_im - {1'b0, pl_i.den}) : tr_im[63:0];
    pl_d.lo_re  = {pl_i.lo_re[30:0], 1'b0};
    pl_d.lo_im  = {pl_i.lo_im[30:0], 1'b0};
    pl_d.q_re   = {pl_i.q_re[cau_pkg::QBITS-2:0], ge_re};
    pl_d.q_im   = {pl_i.q_im[cau_pkg::QBITS-2:0], ge_im};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= pl_d;
    end
  end

  assign pl_o = pl_q;
endmodule
`default_nettype wire

[verif/tb_top.sv]
// testbench for complex_arith_unit: queue-fed driver, checking monitor, bit-exact predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  typedef struct {
    cau_pkg::mode_e     mode;
    logic signed [31:0] a_re, a_im, b_re, b_im;
  } cplx_op_t;

  typedef struct {
    logic [31:0] re, im;
    logic        ov, dz;
  } cplx_res_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic op_valid_i = 1'b0;
  logic op_ready_o;
  logic [1:0] mode_i = 2'd0;
  logic signed [31:0] a_re_i = '0, a_im_i = '0, b_re_i = '0, b_im_i = '0;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  logic signed [31:0] res_re_o, res_im_o;
  logic overflow_o, div_zero_o;

  cplx_op_t  pending_ops[$];
  cplx_res_t expected_res[$];
  int        op_gap = 0;
  int        res_stall = 0;
  int        long_hold = 0;
  int        results_seen = 0;
  int        idle_cycles = 0;
  bit        hold_done = 1'b0;
  bit        failed = 1'b0;

  complex_arith_unit u_dut (
    .clk_i, .rst_ni, .op_valid_i, .op_ready_o, .mode_i,
    .a_re_i, .a_im_i, .b_re_i, .b_im_i,
    .res_valid_o, .res_ready_i, .res_re_o, .res_im_o, .overflow_o, .div_zero_o
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] sat_q32(logic signed [127:0] v, inout logic ov);
    if (v > 128'sd2147483647) begin
      ov = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] div_q32(logic signed [127:0] num, logic [127:0] den,
                                          inout logic ov);
    logic               neg;
    logic [127:0]       mag;
    logic [127:0]       q;
    logic signed [127:0] sq;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (mag << 16) / den;
    sq = neg ? -$signed(q) : $signed(q);
    return sat_q32(sq, ov);
  endfunction

  function automatic cplx_res_t cplx_predict(cplx_op_t op);
    cplx_res_t r;
    logic signed [127:0] a, b, c, d, s1, s2;
    logic [127:0] den;
    a = op.a_re; b = op.a_im; c = op.b_re; d = op.b_im;
    r = '{re: '0, im: '0, ov: 1'b0, dz: 1'b0};
    case (op.mode)
      cau_pkg::MODE_ADD: begin
        r.re = sat_q32(a + c, r.ov);
        r.im = sat_q32(b + d, r.ov);
      end
      cau_pkg::MODE_SUB: begin
        r.re = sat_q32(a - c, r.ov);
        r.im = sat_q32(b - d, r.ov);
      end
      cau_pkg::MODE_MUL: begin
        s1 = a * c - b * d;
        s2 = a * d + b * c;
        r.re = sat_q32(s1 >>> 16, r.ov);
        r.im = sat_q32(s2 >>> 16, r.ov);
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = div_q32(a * c + b * d, den, r.ov);
          r.im = div_q32(b * c - a * d, den, r.ov);
        end
      end
    endcase
    return r;
  endfunction

  function automatic int draw_wait();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 13);
    return 0;
  endfunction

  function automatic logic signed [31:0] rand_part(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      2: return $signed($urandom_range(0, 2047)) - 32'sd1024;
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  function automatic cplx_op_t rand_op();
    cplx_op_t op;
    int k;
    k = $urandom_range(0, 9);
    op.mode = cau_pkg::mode_e'($urandom_range(0, 3));
    op.a_re = rand_part(k < 3 ? 0 : (k < 8 ? 1 : (k == 8 ? 2 : 3)));
    op.a_im = rand_part(k < 3 ? 0 : (k < 8 ? 1 : (k == 8 ? 2 : 3)));
    op.b_re = rand_part(k < 3 ? 0 : (k < 8 ? 1 : 2));
    op.b_im = rand_part(k < 3 ? 0 : (k < 8 ? 1 : 2));
    if ($urandom_range(0, 19) == 0) begin
      op.b_re = 0;
      op.b_im = 0;
    end
    return op;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    int g;
    if (!rst_ni) begin
      op_valid_i <= 1'b0;
      op_gap <= 0;
    end else begin
      g = op_gap;
      if (op_valid_i && op_ready_o) begin
        expected_res.push_back(cplx_predict(pending_ops.pop_front()));
        g = draw_wait();
      end
      if (op_valid_i && !op_ready_o) begin
      end else if (g == 0 && pending_ops.size() > 0) begin
        op_valid_i <= 1'b1;
        mode_i <= pending_ops[0].mode;
        a_re_i <= pending_ops[0].a_re;
        a_im_i <= pending_ops[0].a_im;
        b_re_i <= pending_ops[0].b_re;
        b_im_i <= pending_ops[0].b_im;
        op_gap <= 0;
      end else begin
        op_valid_i <= 1'b0;
        op_gap <= (g > 0) ? g - 1 : 0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    int s;
    int h;
    cplx_res_t e;
    if (!rst_ni) begin
      res_ready_i <= 1'b0;
      res_stall <= 0;
      long_hold <= 0;
    end else begin
      s = res_stall > 0 ? res_stall - 1 : 0;
      h = long_hold > 0 ? long_hold - 1 : 0;
      if (res_valid_o && res_ready_i) begin
        results_seen <= results_seen + 1;
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected transaction re=%h im=%h", $time, res_re_o, res_im_o);
          failed <= 1'b1;
        end else begin
          e = expected_res.pop_front();
          if (res_re_o !== e.re || res_im_o !== e.im || overflow_o !== e.ov ||
              div_zero_o !== e.dz) begin
            $display("%0t: mismatch expected re=%h im=%h ov=%b dz=%b actual re=%h im=%h ov=%b dz=%b",
                     $time, e.re, e.im, e.ov, e.dz, res_re_o, res_im_o, overflow_o, div_zero_o);
            failed <= 1'b1;
          end
        end
        s = draw_wait();
        if (!hold_done && results_seen == 150) begin
          h = 120;
          hold_done <= 1'b1;
        end
      end
      res_stall <= s;
      long_hold <= h;
      res_ready_i <= (s == 0 && h == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_valid_i && op_ready_o) || (res_valid_o && res_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout", $time);
        $display("[complex_arith_unit] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    cplx_op_t op;
    logic signed [31:0] ext[4];
    #1 rst_ni = 1'b0;
    ext = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'sh0001_0000};
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 4; i++) begin
        op.mode = cau_pkg::mode_e'(m);
        op.a_re = ext[i];
        op.a_im = ext[3 - i];
        op.b_re = ext[(i + 1) % 4];
        op.b_im = ext[(i + 2) % 4];
        pending_ops.push_back(op);
      end
    end
    // divide by zero, tiny divisor, negative rounding, multiply rounding and saturation, subtract saturation
    pending_ops.push_back('{cau_pkg::MODE_DIV, 32'sh0003_0000, -32'sh0002_0000, 32'sd0, 32'sd0});
    pending_ops.push_back('{cau_pkg::MODE_DIV, 32'sh0001_0000, 32'sh0001_0000, 32'sd1, 32'sd0});
    pending_ops.push_back('{cau_pkg::MODE_DIV, -32'sh0001_0000, 32'sd1, 32'sh0003_0000, 32'sd0});
    pending_ops.push_back('{cau_pkg::MODE_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1});
    pending_ops.push_back('{cau_pkg::MODE_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7fff_ffff});
    pending_ops.push_back('{cau_pkg::MODE_SUB, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd1, -32'sd1});
    for (int i = 0; i < 450; i++) pending_ops.push_back(rand_op());
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_ops.size() == 0 && !op_valid_i && expected_res.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_res.size() != 0) begin
      $display("%0t: %0d transactions never arrived", $time, expected_res.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("[complex_arith_unit] OK");
    end else begin
      $display("[complex_arith_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
